>>> hdl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CHK_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/impt_pkg.sv
// Types and constants of the in-place matrix transpose block.
package impt_pkg;

	localparam int DIM_W     = 13;
	localparam int ELEM_AW   = 12;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_XPOSE = 2'd1,
		REQ_READ  = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT = 2'd2;

	typedef struct packed {
		logic st_rd;
		logic st_wr;
		logic st_wr_ext;
		logic sc_wr;
		logic res_load;
		logic res_status;
		logic res_zero;
	} dp_cmd_t;

endpackage

>>> hdl/in_place_matrix_transpose.sv
// Top level of the in-place matrix transpose block.
// Usage:
//   Input channel (in_valid/in_stall) carries requests: element write,
//   transpose command or element read, addressed linearly by elem_addr.
//   Output channel (out_valid/out_stall) returns one transfer per read
//   (rd_word, status 0) and per transpose (rd_word 0, status 1 if
//   rows*cols exceeds MAX_ELEMS). Writes return nothing.
//   Configuration: rows, cols and layout_row_major via cfg_wr_en/cfg_idx/
//   cfg_wdata, written while the block is idle.
// Timing:
//   Writes and reads take one item per cycle while in_stall is low; a read
//   result appears in the cycle after its transfer.
//   A transpose of m*n elements runs one store-to-scratch copy pass and one
//   transposing write-back pass, each one element per cycle through the
//   store. Refused or empty transposes answer in the cycle after their
//   transfer.
// Reset: arst_n clears control and configuration (rows 1, cols 1,
//   row-major); store contents are undefined until written.
// Stall: a held result keeps its payload; while it is stalled or a
//   transpose runs, in_stall is high.
module in_place_matrix_transpose
	import impt_pkg::*;
#(
	parameter int MAX_ELEMS  = 4096,
	parameter int WORD_WIDTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            req_type,
	input  logic [ELEM_AW-1:0]    elem_addr,
	input  logic [WORD_WIDTH-1:0] wr_word,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [WORD_WIDTH-1:0] rd_word,
	output logic                  status,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [DIM_W-1:0]      cfg_wdata
);

	localparam int AW = $clog2(MAX_ELEMS);

	dp_cmd_t       cmd;
	logic          out_busy;
	logic [AW-1:0] st_rd_addr, st_wr_addr, sc_rd_addr, sc_wr_addr;

	impt_ctrl #(
		.MAX_ELEMS (MAX_ELEMS),
		.AW        (AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.elem_addr  (elem_addr),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.out_busy   (out_busy),
		.cmd        (cmd),
		.st_rd_addr (st_rd_addr),
		.st_wr_addr (st_wr_addr),
		.sc_rd_addr (sc_rd_addr),
		.sc_wr_addr (sc_wr_addr)
	);

	impt_dp #(
		.MAX_ELEMS  (MAX_ELEMS),
		.WORD_WIDTH (WORD_WIDTH),
		.AW         (AW)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st_rd_addr (st_rd_addr),
		.st_wr_addr (st_wr_addr),
		.sc_rd_addr (sc_rd_addr),
		.sc_wr_addr (sc_wr_addr),
		.wr_word    (wr_word),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.out_busy   (out_busy),
		.rd_word    (rd_word),
		.status     (status)
	);

endmodule

>>> hdl/impt_dp.sv
// Datapath: matrix store, scratch buffer and result register.
module impt_dp
	import impt_pkg::*;
#(
	parameter int MAX_ELEMS  = 4096,
	parameter int WORD_WIDTH = 64,
	parameter int AW         = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	input  logic [AW-1:0]         st_rd_addr,
	input  logic [AW-1:0]         st_wr_addr,
	input  logic [AW-1:0]         sc_rd_addr,
	input  logic [AW-1:0]         sc_wr_addr,
	input  logic [WORD_WIDTH-1:0] wr_word,
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic                  out_busy,
	output logic [WORD_WIDTH-1:0] rd_word,
	output logic                  status
);

	logic [WORD_WIDTH-1:0] store_mem [MAX_ELEMS];
	logic [WORD_WIDTH-1:0] scratch_mem [MAX_ELEMS];
	logic [WORD_WIDTH-1:0] st_rd_q;
	logic [WORD_WIDTH-1:0] sc_rd_q;
	logic                  out_valid_q;
	logic                  status_q;
	logic                  zero_q;

	always_ff @(posedge clk) begin
		if (cmd.st_wr) begin
			store_mem[st_wr_addr] <= cmd.st_wr_ext ? wr_word : sc_rd_q;
		end
		if (cmd.st_rd) begin
			st_rd_q <= store_mem[st_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sc_wr) begin
			scratch_mem[sc_wr_addr] <= st_rd_q;
		end
		sc_rd_q <= scratch_mem[sc_rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status_q <= cmd.res_status;
			zero_q   <= cmd.res_zero;
		end
	end

	assign out_valid = out_valid_q;
	assign out_busy  = out_valid_q & out_stall;
	assign rd_word   = zero_q ? '0 : st_rd_q;
	assign status    = status_q;

endmodule

>>> hdl/impt_ctrl.sv
// Controller: configuration registers, request decode and transpose sequencer.
module impt_ctrl
	import impt_pkg::*;
#(
	parameter int MAX_ELEMS = 4096,
	parameter int AW        = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           req_type,
	input  logic [ELEM_AW-1:0]   elem_addr,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [DIM_W-1:0]     cfg_wdata,
	input  logic                 out_busy,
	output dp_cmd_t              cmd,
	output logic [AW-1:0]        st_rd_addr,
	output logic [AW-1:0]        st_wr_addr,
	output logic [AW-1:0]        sc_rd_addr,
	output logic [AW-1:0]        sc_wr_addr
);

	localparam int CW = AW + 1;
	localparam int XW = (AW > ELEM_AW) ? AW : ELEM_AW;
	localparam int PW = 2 * DIM_W;

	typedef enum logic [2:0] {S_IDLE, S_COPY, S_GAP, S_XPOSE, S_FIN} state_t;

	state_t           state_q;
	logic [DIM_W-1:0] rows_q, cols_q;
	logic             major_q;
	logic [DIM_W-1:0] m_q, n_q, i_q, j_q;
	logic [CW-1:0]    total_q, cnt_q, src_q;
	logic             wpend_s1, wsel_s1;
	logic [AW-1:0]    waddr_s1;

	logic          accept;
	logic [XW-1:0] addr_x;
	logic          addr_ok;
	logic [PW-1:0] prod;
	logic          oversize;
	logic          empty;
	req_t          req;

	assign req      = req_t'(req_type);
	assign in_stall = (state_q != S_IDLE) | out_busy;
	assign accept   = in_valid & ~in_stall;
	assign addr_x   = XW'(elem_addr);
	assign addr_ok  = {1'b0, addr_x} < (XW + 1)'(MAX_ELEMS);
	assign prod     = PW'(rows_q) * PW'(cols_q);
	assign oversize = prod > PW'(MAX_ELEMS);
	assign empty    = prod == '0;

	always_comb begin
		cmd        = '0;
		st_rd_addr = cnt_q[AW-1:0];
		st_wr_addr = waddr_s1;
		sc_rd_addr = src_q[AW-1:0];
		sc_wr_addr = waddr_s1;
		if (wpend_s1) begin
			cmd.sc_wr = ~wsel_s1;
			cmd.st_wr = wsel_s1;
		end
		unique case (state_q)
			S_IDLE: begin
				st_rd_addr = addr_x[AW-1:0];
				st_wr_addr = addr_x[AW-1:0];
				if (accept) begin
					unique case (req)
						REQ_WRITE: begin
							cmd.st_wr     = addr_ok;
							cmd.st_wr_ext = 1'b1;
						end
						REQ_READ: begin
							cmd.st_rd    = 1'b1;
							cmd.res_load = 1'b1;
							cmd.res_zero = ~addr_ok;
						end
						REQ_XPOSE: begin
							cmd.res_load   = oversize | empty;
							cmd.res_status = oversize;
							cmd.res_zero   = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			S_COPY:  cmd.st_rd = 1'b1;
			S_GAP:   begin
			end
			S_XPOSE: begin
			end
			S_FIN: begin
				cmd.res_load = 1'b1;
				cmd.res_zero = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= DIM_W'(1);
			cols_q  <= DIM_W'(1);
			major_q <= 1'b1;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx)
				CFG_ROWS:   rows_q  <= cfg_wdata;
				CFG_COLS:   cols_q  <= cfg_wdata;
				CFG_LAYOUT: major_q <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			wpend_s1 <= 1'b0;
			wsel_s1  <= 1'b0;
			waddr_s1 <= '0;
			m_q      <= '0;
			n_q      <= '0;
			i_q      <= '0;
			j_q      <= '0;
			total_q  <= '0;
			cnt_q    <= '0;
			src_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					wpend_s1 <= 1'b0;
					if (accept && req == REQ_XPOSE && !oversize && !empty) begin
						m_q     <= major_q ? rows_q : cols_q;
						n_q     <= major_q ? cols_q : rows_q;
						total_q <= CW'(prod);
						cnt_q   <= '0;
						state_q <= S_COPY;
					end
				end
				S_COPY: begin
					wpend_s1 <= 1'b1;
					wsel_s1  <= 1'b0;
					waddr_s1 <= cnt_q[AW-1:0];
					cnt_q    <= cnt_q + CW'(1);
					if (cnt_q == total_q - CW'(1)) begin
						state_q <= S_GAP;
					end
				end
				S_GAP: begin
					wpend_s1 <= 1'b0;
					i_q      <= '0;
					j_q      <= '0;
					src_q    <= '0;
					cnt_q    <= '0;
					state_q  <= S_XPOSE;
				end
				S_XPOSE: begin
					wpend_s1 <= 1'b1;
					wsel_s1  <= 1'b1;
					waddr_s1 <= cnt_q[AW-1:0];
					cnt_q    <= cnt_q + CW'(1);
					if (i_q == m_q - DIM_W'(1)) begin
						i_q   <= '0;
						j_q   <= j_q + DIM_W'(1);
						src_q <= CW'(j_q) + CW'(1);
					end else begin
						i_q   <= i_q + DIM_W'(1);
						src_q <= src_q + CW'(n_q);
					end
					if (cnt_q == total_q - CW'(1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					wpend_s1 <= 1'b0;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> hdl/impt_chk.sv
// Port-level checker for the in-place matrix transpose block, with its bind.
`include "assert_macros.svh"

module impt_chk
	import impt_pkg::*;
#(
	parameter int WORD_WIDTH = 64
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic [1:0]            req_type,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [WORD_WIDTH-1:0] rd_word,
	input logic                  status
);

	`CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result dropped")
	`CHK_NEXT(a_out_stable, out_valid && out_stall, $stable(rd_word) && $stable(status), "stalled result changed")
	`CHK_NOW(a_refuse_zero, out_valid && status, rd_word == '0, "refused transpose with data")
	`CHK_NOW(a_no_take_stalled, out_valid && out_stall, in_stall, "input taken over held result")
	`CHK_NEXT(a_write_silent, in_valid && !in_stall && req_type == REQ_WRITE && !out_valid, !out_valid, "write produced a result")

endmodule

bind in_place_matrix_transpose impt_chk #(.WORD_WIDTH(WORD_WIDTH)) u_chk (.*);
